[hdl/blfs_pkg.sv]
// ----------------------------------------------------------------------------
// Brake light flash sequencer package
// Shared types, codes and the flash mode tables.
// ----------------------------------------------------------------------------
package blfs_pkg;

    localparam int unsigned LevelWidth = 8;
    localparam int unsigned ModeWidth  = 4;
    localparam int unsigned TickWidth  = 9;
    localparam int unsigned CountWidth = 6;
    localparam int unsigned CfgIdxWidth = 2;

    // Opcodes of an input item.
    localparam logic OpTick  = 1'b0;
    localparam logic OpStart = 1'b1;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CfgMinLevel = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgMaxLevel = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgMaxMode  = 2'd2;

    localparam logic [LevelWidth-1:0] SolidLevel   = 8'd255;
    localparam logic [LevelWidth-1:0] MinLevelRst  = 8'd0;
    localparam logic [LevelWidth-1:0] MaxLevelRst  = 8'd255;
    localparam logic [ModeWidth-1:0]  MaxModeRst   = 4'd11;
    localparam logic [ModeWidth-1:0]  FirstFlash   = 4'd1;
    localparam logic [ModeWidth-1:0]  LastFlash    = 4'd10;
    localparam logic [ModeWidth-1:0]  RampMode     = 4'd11;
    localparam logic [CountWidth-1:0] RampCount    = 6'd8;

    typedef struct packed {
        logic opcode;
        logic button_pressed;
    } item_t;

    typedef struct packed {
        logic                   we;
        logic [CfgIdxWidth-1:0] index;
        logic [LevelWidth-1:0]  data;
    } cfg_wr_t;

    // Half-period in ms of each flash mode; zero for modes without flashing.
    function automatic logic [TickWidth-1:0] half_ms(input logic [ModeWidth-1:0] mode);
        logic [TickWidth-1:0] h;
        case (mode)
            4'd1, 4'd2:  h = 9'd333;
            4'd3, 4'd4:  h = 9'd166;
            4'd5, 4'd6:  h = 9'd83;
            4'd7, 4'd8:  h = 9'd55;
            4'd9, 4'd10: h = 9'd41;
            default:     h = 9'd0;
        endcase
        return h;
    endfunction

    // Number of flashes of each flash mode.
    function automatic logic [CountWidth-1:0] flash_cnt(input logic [ModeWidth-1:0] mode);
        logic [CountWidth-1:0] c;
        case (mode)
            4'd1:    c = 6'd3;
            4'd2:    c = 6'd8;
            4'd3:    c = 6'd6;
            4'd4:    c = 6'd15;
            4'd5:    c = 6'd12;
            4'd6:    c = 6'd30;
            4'd7:    c = 6'd18;
            4'd8:    c = 6'd45;
            4'd9:    c = 6'd24;
            4'd10:   c = 6'd60;
            default: c = 6'd0;
        endcase
        return c;
    endfunction

endpackage

[hdl/blfs_if.sv]
// ----------------------------------------------------------------------------
// Brake light flash sequencer channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface blfs_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic button_pressed;

    modport source (output valid, output opcode, output button_pressed, input ready);
    modport sink   (input valid, input opcode, input button_pressed, output ready);
endinterface

interface blfs_out_if;
    logic                             valid;
    logic                             ready;
    logic [blfs_pkg::LevelWidth-1:0]  level;
    logic [blfs_pkg::ModeWidth-1:0]   active_mode;
    logic                             busy_res;

    modport source (output valid, output level, output active_mode, output busy_res,
                    input ready);
    modport sink   (input valid, input level, input active_mode, input busy_res,
                    output ready);
endinterface

[hdl/blfs_in_stage.sv]
// ----------------------------------------------------------------------------
// Brake light flash sequencer input register
// Registers each input item and passes it on when the engine takes it.
// ----------------------------------------------------------------------------
module blfs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    blfs_in_if.sink           in_ch,
    output blfs_pkg::item_t   item,
    output logic              item_valid,
    input  logic              item_ready
);

    logic            valid_reg;
    blfs_pkg::item_t item_reg;

    assign in_ch.ready = !valid_reg || item_ready;
    assign item        = item_reg;
    assign item_valid  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.opcode         <= in_ch.opcode;
            item_reg.button_pressed <= in_ch.button_pressed;
        end
    end

endmodule

[hdl/blfs_engine.sv]
// ----------------------------------------------------------------------------
// Brake light flash sequencer engine
// Pattern state, configuration registers and the result register.
// ----------------------------------------------------------------------------
module blfs_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  blfs_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_ready,
    input  blfs_pkg::cfg_wr_t cfg,
    blfs_out_if.source        out_ch
);

    typedef enum logic [2:0] {
        PhIdle = 3'd0,
        PhLow  = 3'd1,
        PhHigh = 3'd2,
        PhTail = 3'd3,
        PhUp   = 3'd4,
        PhDown = 3'd5
    } phase_t;

    logic [blfs_pkg::LevelWidth-1:0] min_level_reg;
    logic [blfs_pkg::LevelWidth-1:0] max_level_reg;
    logic [blfs_pkg::ModeWidth-1:0]  max_mode_reg;

    phase_t                          phase_reg, phase_next;
    logic [blfs_pkg::ModeWidth-1:0]  mode_reg, mode_next;
    logic [blfs_pkg::TickWidth-1:0]  tick_reg, tick_next;
    logic [blfs_pkg::CountWidth-1:0] cycles_reg, cycles_next;
    logic [blfs_pkg::LevelWidth-1:0] ramp_reg, ramp_next;
    logic [blfs_pkg::LevelWidth-1:0] level_reg, level_next;

    logic                            res_valid_reg;
    logic [blfs_pkg::LevelWidth-1:0] res_level_reg;
    logic [blfs_pkg::ModeWidth-1:0]  res_mode_reg;
    logic                            res_busy_reg;

    logic                            fire;
    logic [blfs_pkg::ModeWidth:0]    mode_inc;
    logic [blfs_pkg::ModeWidth-1:0]  start_mode;
    logic [blfs_pkg::TickWidth:0]    tick_inc;
    logic [blfs_pkg::TickWidth-1:0]  half;
    logic [blfs_pkg::CountWidth-1:0] cycles_dec;
    logic                            ramp_ok;
    logic [blfs_pkg::LevelWidth:0]   ramp_inc;
    logic [blfs_pkg::LevelWidth:0]   min_inc;

    assign item_ready = !res_valid_reg || out_ch.ready;
    assign fire       = item_valid && item_ready;

    assign mode_inc   = {1'b0, mode_reg} + 5'd1;
    assign start_mode = !item.button_pressed ? mode_reg :
                        (mode_inc > {1'b0, max_mode_reg}) ? '0 :
                        mode_inc[blfs_pkg::ModeWidth-1:0];
    assign tick_inc   = {1'b0, tick_reg} + 10'd1;
    assign half       = blfs_pkg::half_ms(mode_reg);
    assign cycles_dec = (cycles_reg != '0) ? cycles_reg - 6'd1 : '0;
    assign ramp_ok    = min_level_reg < max_level_reg;
    assign ramp_inc   = {1'b0, ramp_reg} + 9'd1;
    assign min_inc    = {1'b0, min_level_reg} + 9'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        tick_next   = tick_reg;
        cycles_next = cycles_reg;
        ramp_next   = ramp_reg;
        level_next  = level_reg;
        if (item.opcode == blfs_pkg::OpStart)
        begin
            mode_next = start_mode;
            tick_next = '0;
            if (start_mode >= blfs_pkg::FirstFlash && start_mode <= blfs_pkg::LastFlash)
            begin
                cycles_next = blfs_pkg::flash_cnt(start_mode);
                phase_next  = PhLow;
                level_next  = min_level_reg;
            end
            else if (start_mode == blfs_pkg::RampMode && ramp_ok)
            begin
                cycles_next = blfs_pkg::RampCount;
                phase_next  = PhUp;
                ramp_next   = min_level_reg;
                level_next  = min_level_reg;
            end
            else
            begin
                phase_next  = PhIdle;
                cycles_next = '0;
                level_next  = blfs_pkg::SolidLevel;
            end
        end
        else
        begin
            case (phase_reg)
                PhLow, PhHigh, PhTail:
                begin
                    if (tick_inc < {1'b0, half})
                    begin
                        tick_next = tick_inc[blfs_pkg::TickWidth-1:0];
                    end
                    else
                    begin
                        tick_next = '0;
                        if (phase_reg == PhLow)
                        begin
                            phase_next = PhHigh;
                            level_next = max_level_reg;
                        end
                        else if (phase_reg == PhHigh)
                        begin
                            cycles_next = cycles_dec;
                            level_next  = (cycles_dec != '0) ? min_level_reg : max_level_reg;
                            phase_next  = (cycles_dec != '0) ? PhLow : PhTail;
                        end
                        else
                        begin
                            phase_next  = PhIdle;
                            cycles_next = '0;
                            level_next  = blfs_pkg::SolidLevel;
                        end
                    end
                end
                PhUp, PhDown:
                begin
                    if (phase_reg == PhUp && ramp_inc < {1'b0, max_level_reg})
                    begin
                        ramp_next  = ramp_inc[blfs_pkg::LevelWidth-1:0];
                        level_next = ramp_inc[blfs_pkg::LevelWidth-1:0];
                    end
                    else if (phase_reg == PhUp && ramp_ok)
                    begin
                        phase_next = PhDown;
                        ramp_next  = max_level_reg;
                        level_next = max_level_reg;
                    end
                    else if (phase_reg == PhDown && {1'b0, ramp_reg} > min_inc)
                    begin
                        ramp_next  = ramp_reg - 8'd1;
                        level_next = ramp_reg - 8'd1;
                    end
                    else if (cycles_dec != '0 && ramp_ok)
                    begin
                        // One ramp done; the next one starts from the floor.
                        cycles_next = cycles_dec;
                        phase_next  = PhUp;
                        ramp_next   = min_level_reg;
                        level_next  = min_level_reg;
                    end
                    else
                    begin
                        phase_next  = PhIdle;
                        tick_next   = '0;
                        cycles_next = '0;
                        level_next  = blfs_pkg::SolidLevel;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg <= blfs_pkg::MinLevelRst;
            max_level_reg <= blfs_pkg::MaxLevelRst;
            max_mode_reg  <= blfs_pkg::MaxModeRst;
            phase_reg     <= PhIdle;
            mode_reg      <= '0;
            tick_reg      <= '0;
            cycles_reg    <= '0;
            ramp_reg      <= '0;
            level_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_level_reg <= '0;
            res_mode_reg  <= '0;
            res_busy_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.we)
            begin
                case (cfg.index)
                    blfs_pkg::CfgMinLevel: min_level_reg <= cfg.data;
                    blfs_pkg::CfgMaxLevel: max_level_reg <= cfg.data;
                    blfs_pkg::CfgMaxMode:  max_mode_reg  <= cfg.data[blfs_pkg::ModeWidth-1:0];
                    default:               max_mode_reg  <= max_mode_reg;
                endcase
            end
            if (fire)
            begin
                phase_reg     <= phase_next;
                mode_reg      <= mode_next;
                tick_reg      <= tick_next;
                cycles_reg    <= cycles_next;
                ramp_reg      <= ramp_next;
                level_reg     <= level_next;
                res_valid_reg <= 1'b1;
                res_level_reg <= level_next;
                res_mode_reg  <= mode_next;
                res_busy_reg  <= (phase_next != PhIdle);
            end
            else if (out_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.level       = res_level_reg;
    assign out_ch.active_mode = res_mode_reg;
    assign out_ch.busy_res    = res_busy_reg;

`ifndef ASSERT_OFF
    // A busy result can only come from a flash mode or the ramp mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_busy_reg) |->
        (res_mode_reg >= blfs_pkg::FirstFlash && res_mode_reg <= blfs_pkg::RampMode))
        else $error("busy result with a bypass mode");

    // The cycle counter is always cleared once a pattern is over.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PhIdle) |-> (cycles_reg == '0))
        else $error("cycles left while idle");

    // During a flash the tick counter stays below the mode's half-period.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PhLow || phase_reg == PhHigh || phase_reg == PhTail) |->
        (tick_reg < half && half != '0))
        else $error("tick counter out of range during a flash");

    // A tick while idle repeats the held level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.opcode == blfs_pkg::OpTick && phase_reg == PhIdle) |=>
        (res_level_reg == $past(level_reg) && $stable(level_reg)))
        else $error("idle tick changed the level");
`endif

endmodule

[hdl/brake_light_flash_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// Brake light flash sequencer
// Turns start events and millisecond ticks into lamp brightness levels.
// ----------------------------------------------------------------------------
// Each input item gives exactly one result item. An item is taken into an
// input register, then the engine updates the pattern state in a single step
// and loads the result register. One item is accepted per clock for as long
// as results are taken. The rate is set by the single-step state update in
// the engine.
// Configuration writes take effect at the next clock edge.
module brake_light_flash_sequencer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    blfs_in_if.sink                             in_ch,
    blfs_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [blfs_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [blfs_pkg::LevelWidth-1:0]     cfg_data
);

    blfs_pkg::item_t   item;
    logic              item_valid;
    logic              item_ready;
    blfs_pkg::cfg_wr_t cfg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    blfs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    blfs_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cfg        (cfg),
        .out_ch     (out_ch)
    );

endmodule
